### design/fbr_pkg.sv
// Shared types, constants and helpers for the fractional box blur row block.
`default_nettype none

package fbr_pkg;

    // Jobs the front end may queue ahead of the back end
    localparam int QUEUE_DEPTH = 4;

    // Row position counter, saturating
    localparam int         POS_W   = 7;
    localparam logic [6:0] POS_CAP = 7'd127;

    // Effective radius plus one must fit
    localparam int RAD_W = 6;

    // Result formatting
    localparam int          OUT_W      = 15;
    localparam logic [14:0] BLUR_MAX   = 15'h7fff;
    localparam int          OUT_SHIFT  = 24;
    localparam int          ROUND_HALF = 1 << (OUT_SHIFT - 1);

    typedef struct packed {
        logic [4:0]  radius_whole;
        logic [7:0]  radius_fraction;
        logic [16:0] norm_recip;
        logic [14:0] zero_threshold;
    } t_cfg;

    // Classification of one accepted sample
    typedef struct packed {
        logic [POS_W-1:0] pos;          // index of the newest sample in the row
        logic             eor;          // row ends here: flush pending results
        logic             emit_centre;  // a regular result is due
    } t_job;

    typedef enum logic [1:0] {
        REG_RADIUS_WHOLE    = 2'd0,
        REG_RADIUS_FRACTION = 2'd1,
        REG_NORM_RECIP      = 2'd2,
        REG_ZERO_THRESHOLD  = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        B_IDLE,
        B_START,
        B_SUM,
        B_DRAIN,
        B_MUL,
        B_SCALE
    } t_back_state;

    // Clamp the programmed radius to what the window store holds
    function automatic logic [RAD_W-1:0] eff_radius(input logic [4:0]       rw,
                                                    input logic [RAD_W-1:0] max_r);
        logic [RAD_W-1:0] ext;
        ext = {1'b0, rw};
        return (ext > max_r) ? max_r : ext;
    endfunction

endpackage

`default_nettype wire

### design/fractional_box_blur_row.sv
// Top level of the fractional-radius horizontal box blur: configuration and wiring.
`default_nettype none

// Fractional box blur over one row. Samples (signed Q3.12) arrive one per
// transaction on the slave stream, tlast on the row's final sample. Each
// result is norm_recip times the window sum with inner taps at full weight
// and the two outer taps at radius_fraction, rounded, saturated to 32767 and
// zeroed below zero_threshold; taps outside the row take the nearest edge
// sample. The result for position x leaves once sample x+r+1 is in, and the
// row's last sample flushes the rest, the final one carrying tlast. The
// front end accepts a sample whenever its four-entry job queue has room.
// The back end walks the window one store read per cycle (r the clamped
// whole radius); a sample that yields no result is only taken from the
// queue, and a row end adds up to r+1 further results. The output register
// lets the back end finish the next result while the current one waits.
// Registers sit on an APB port at byte addresses 0, 4, 8 and 12, and should
// be written only while no results are pending.

module fractional_box_blur_row
    import fbr_pkg::*;
#(
    parameter int MAX_RADIUS  = 31,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // APB configuration
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [3:0]                         paddr,
    input  wire logic [31:0]                        pwdata,
    output logic      [31:0]                        prdata,
    output logic                                    pready,
    // Sample stream; tdata: sample
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]   s_axis_tdata,
    input  wire logic                               s_axis_tlast,
    // Result stream; tdata: blurred, then zero padding
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [15:0]                             m_axis_tdata,
    output logic                                    m_axis_tlast
);

    localparam int STORE_DEPTH = 2 * MAX_RADIUS + 3;
    // Deep enough that queued samples never overwrite a window in use
    localparam int MEM_AW      = $clog2(STORE_DEPTH + QUEUE_DEPTH);
    localparam int JOB_W       = $bits(t_job);
    localparam int QW          = MEM_AW + SAMPLE_BITS + JOB_W;

    t_cfg                   r_cfg;
    logic                   w_cfg_wr;

    logic                   w_full;
    logic                   w_empty;
    logic                   w_push;
    logic                   w_pop;
    t_job                   w_job_in;
    logic [MEM_AW-1:0]      w_ptr_in;
    logic [SAMPLE_BITS-1:0] w_edge_in;
    logic [QW-1:0]          w_q_out;
    logic                   w_wr_en;
    logic [MEM_AW-1:0]      w_wr_addr;
    logic [SAMPLE_BITS-1:0] w_wr_data;
    logic [OUT_W-1:0]       w_blurred;
    logic [RAD_W-1:0]       w_radius;

    // Configuration: write on the access phase, pready tied high
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.radius_whole    <= 5'd1;
            r_cfg.radius_fraction <= 8'd0;
            r_cfg.norm_recip      <= 17'd21845;
            r_cfg.zero_threshold  <= 15'd1;
        end else if (w_cfg_wr) begin
            case (t_reg_idx'(paddr[3:2]))
                REG_RADIUS_WHOLE:    r_cfg.radius_whole    <= pwdata[4:0];
                REG_RADIUS_FRACTION: r_cfg.radius_fraction <= pwdata[7:0];
                REG_NORM_RECIP:      r_cfg.norm_recip      <= pwdata[16:0];
                REG_ZERO_THRESHOLD:  r_cfg.zero_threshold  <= pwdata[14:0];
                default:             r_cfg                 <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[3:2]))
            REG_RADIUS_WHOLE:    prdata = 32'(r_cfg.radius_whole);
            REG_RADIUS_FRACTION: prdata = 32'(r_cfg.radius_fraction);
            REG_NORM_RECIP:      prdata = 32'(r_cfg.norm_recip);
            REG_ZERO_THRESHOLD:  prdata = 32'(r_cfg.zero_threshold);
            default:             prdata = '0;
        endcase
    end

    // The front end needs the clamped radius to decide whether a result is due
    assign w_radius = eff_radius(r_cfg.radius_whole, RAD_W'(MAX_RADIUS));

    fbr_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MEM_AW      (MEM_AW)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_radius     (w_radius),
        .i_s_tvalid   (s_axis_tvalid),
        .o_s_tready   (s_axis_tready),
        .i_sample     (s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_eor        (s_axis_tlast),
        .i_queue_full (w_full),
        .o_push       (w_push),
        .o_job        (w_job_in),
        .o_ptr        (w_ptr_in),
        .o_edge       (w_edge_in),
        .o_wr_en      (w_wr_en),
        .o_wr_addr    (w_wr_addr),
        .o_wr_data    (w_wr_data)
    );

    fbr_queue #(
        .W     (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_ptr_in, w_edge_in, w_job_in}),
        .i_pop   (w_pop),
        .o_data  (w_q_out),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    fbr_back #(
        .MAX_RADIUS  (MAX_RADIUS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .MEM_AW      (MEM_AW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_wr_en     (w_wr_en),
        .i_wr_addr   (w_wr_addr),
        .i_wr_data   (w_wr_data),
        .i_job_valid (!w_empty),
        .i_job       (t_job'(w_q_out[JOB_W-1:0])),
        .i_job_ptr   (w_q_out[JOB_W+SAMPLE_BITS +: MEM_AW]),
        .i_job_edge  (w_q_out[JOB_W +: SAMPLE_BITS]),
        .o_job_pop   (w_pop),
        .o_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .o_blurred   (w_blurred),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, w_blurred};

endmodule

`default_nettype wire

### design/fbr_queue.sv
// Small register FIFO that parts the front end from the back end.
`default_nettype none

module fbr_queue #(
    parameter int W     = 32,
    parameter int DEPTH = 4
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    input  wire logic         i_pop,
    output logic      [W-1:0] o_data,
    output logic              o_full,
    output logic              o_empty
);

    localparam int AW = $clog2(DEPTH);

    logic [W-1:0] r_mem [DEPTH];
    logic [AW:0]  r_wr;
    logic [AW:0]  r_rd;

    assign o_empty = (r_wr == r_rd);
    assign o_full  = (r_wr[AW] != r_rd[AW]) && (r_wr[AW-1:0] == r_rd[AW-1:0]);
    assign o_data  = r_mem[r_rd[AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr[AW-1:0]] <= i_data;
        end
    end

endmodule

`default_nettype wire

### design/fbr_front.sv
// Front end: accepts samples, writes the window store and classifies each sample.
`default_nettype none

module fbr_front
    import fbr_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int MEM_AW      = 7
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic [RAD_W-1:0]       i_radius,
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    input  wire logic                   i_eor,
    input  wire logic                   i_queue_full,
    output logic                        o_push,
    output t_job                        o_job,
    output logic [MEM_AW-1:0]           o_ptr,
    output logic [SAMPLE_BITS-1:0]      o_edge,
    output logic                        o_wr_en,
    output logic [MEM_AW-1:0]           o_wr_addr,
    output logic [SAMPLE_BITS-1:0]      o_wr_data
);

    logic [POS_W-1:0]       r_pos;
    logic [SAMPLE_BITS-1:0] r_edge;
    logic [MEM_AW-1:0]      r_wptr;

    logic                   w_accept;
    logic [POS_W-1:0]       w_pos_inc;
    logic [POS_W-1:0]       w_p;
    logic [SAMPLE_BITS-1:0] w_edge;

    assign o_s_tready = !i_queue_full;
    assign w_accept   = i_s_tvalid && !i_queue_full;

    assign w_pos_inc = (r_pos != POS_CAP) ? r_pos + 1'b1 : r_pos;
    assign w_p       = w_pos_inc - 1'b1;
    // Latch the row's first sample as the left edge value
    assign w_edge    = (r_pos == '0) ? i_sample : r_edge;

    always_comb begin
        o_job.pos         = w_p;
        o_job.eor         = i_eor;
        o_job.emit_centre = (w_p >= (POS_W'(i_radius) + 1'b1));
    end

    assign o_push    = w_accept;
    assign o_ptr     = r_wptr;
    assign o_edge    = w_edge;
    assign o_wr_en   = w_accept;
    assign o_wr_addr = r_wptr;
    assign o_wr_data = i_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_wptr <= '0;
        end else if (w_accept) begin
            r_pos  <= i_eor ? '0 : w_pos_inc;
            r_wptr <= r_wptr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_edge <= w_edge;
        end
    end

endmodule

`default_nettype wire

### design/fbr_back.sv
// Back end: window store, tap accumulation, scaling and the output register.
`default_nettype none

module fbr_back
    import fbr_pkg::*;
#(
    parameter int MAX_RADIUS  = 31,
    parameter int SAMPLE_BITS = 16,
    parameter int MEM_AW      = 7
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_cfg                   i_cfg,
    input  wire logic                   i_wr_en,
    input  wire logic [MEM_AW-1:0]      i_wr_addr,
    input  wire logic [SAMPLE_BITS-1:0] i_wr_data,
    input  wire logic                   i_job_valid,
    input  wire t_job                   i_job,
    input  wire logic [MEM_AW-1:0]      i_job_ptr,
    input  wire logic [SAMPLE_BITS-1:0] i_job_edge,
    output logic                        o_job_pop,
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    output logic [OUT_W-1:0]            o_blurred,
    output logic                        o_last
);

    localparam int STORE_DEPTH = 2 * MAX_RADIUS + 3;
    localparam int KW          = $clog2(STORE_DEPTH) + 1;
    localparam int ACC_W       = SAMPLE_BITS + 8 + $clog2(STORE_DEPTH);
    localparam int PW          = ACC_W + 18;
    localparam int VW          = (PW - OUT_SHIFT > OUT_W) ? PW - OUT_SHIFT : OUT_W + 1;
    localparam int MEM_DEPTH   = 1 << MEM_AW;

    t_back_state r_state, n_state;

    // Current job
    logic [MEM_AW-1:0]             r_ptr;
    logic signed [SAMPLE_BITS-1:0] r_edge;
    logic [POS_W-1:0]              r_p;
    logic                          r_eor;
    logic                          r_centre;
    logic [RAD_W-1:0]              r_d;

    // Tap walk
    logic signed [KW-1:0]          r_k;
    logic signed [KW-1:0]          r_k_last;
    logic                          r_first;

    logic [SAMPLE_BITS-1:0]        r_mem [MEM_DEPTH];
    logic signed [SAMPLE_BITS-1:0] r_rd;
    logic                          r_iss_q;
    logic                          r_edge_q;
    logic                          r_outer_q;

    logic signed [ACC_W-1:0]       r_acc;
    logic signed [PW-1:0]          r_prod;

    logic                          r_out_valid;
    logic [OUT_W-1:0]              r_out_data;
    logic                          r_out_last;

    logic [RAD_W-1:0]              w_r;
    logic                          w_has_work;
    logic                          w_out_free;
    logic                          w_row_done;
    logic                          w_pop;
    logic                          w_load_out;
    logic [RAD_W-1:0]              w_flush_d_job;
    logic [RAD_W-1:0]              w_flush_d_reg;
    logic signed [8:0]             w_k_lo;
    logic signed [8:0]             w_k_hi;
    logic [MEM_AW-1:0]             w_rd_addr;
    logic                          w_beyond;
    logic                          w_outer;
    logic signed [SAMPLE_BITS-1:0] w_tap;
    logic signed [SAMPLE_BITS+8:0] w_outer_term;
    logic signed [SAMPLE_BITS+7:0] w_inner_term;
    logic signed [ACC_W-1:0]       w_term;
    logic signed [PW-1:0]          w_round;
    logic [VW-1:0]                 w_v;
    logic [OUT_W-1:0]              w_sat;
    logic [OUT_W-1:0]              w_blur;

    assign w_r        = eff_radius(i_cfg.radius_whole, RAD_W'(MAX_RADIUS));
    assign w_has_work = i_job.emit_centre || i_job.eor;
    assign w_out_free = !r_out_valid || i_m_tready;
    // After the regular result, a row end carries on with the flush
    assign w_row_done = r_centre ? !r_eor : (r_d == '0);

    // Flush starts at the smaller of r and the newest position
    assign w_flush_d_job = (POS_W'(w_r) <= i_job.pos) ? w_r : RAD_W'(i_job.pos);
    assign w_flush_d_reg = (POS_W'(w_r) <= r_p) ? w_r : RAD_W'(r_p);

    assign w_k_lo = $signed({3'b000, r_d}) - $signed({3'b000, w_r}) - 9'sd1;
    assign w_k_hi = $signed({3'b000, r_d}) + $signed({3'b000, w_r}) + 9'sd1;

    // Taps ahead of the newest sample clamp to it; taps behind the row start
    // clamp to the edge sample
    assign w_rd_addr = r_k[KW-1] ? r_ptr : r_ptr - MEM_AW'(r_k[KW-2:0]);
    assign w_beyond  = $signed({2'b00, r_p}) < 9'(r_k);
    assign w_outer   = r_first || (r_k == r_k_last);

    assign w_tap        = r_edge_q ? r_edge : r_rd;
    assign w_outer_term = w_tap * $signed({1'b0, i_cfg.radius_fraction});
    assign w_inner_term = {w_tap, 8'h00};
    assign w_term       = r_outer_q ? ACC_W'(w_outer_term) : ACC_W'(w_inner_term);

    assign w_round = r_prod + PW'(ROUND_HALF);
    assign w_v     = VW'(w_round[PW-1:OUT_SHIFT]);
    assign w_sat   = (w_v > VW'(BLUR_MAX)) ? BLUR_MAX : w_v[OUT_W-1:0];
    assign w_blur  = (r_prod[PW-1] || (w_sat < i_cfg.zero_threshold)) ? '0 : w_sat;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (i_job_valid && w_has_work) begin
                    n_state = B_START;
                end
            end
            B_START: n_state = B_SUM;
            B_SUM: begin
                if (r_k == r_k_last) begin
                    n_state = B_DRAIN;
                end
            end
            B_DRAIN: n_state = B_MUL;
            B_MUL:   n_state = B_SCALE;
            B_SCALE: begin
                if (w_out_free) begin
                    n_state = w_row_done ? B_IDLE : B_START;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        w_pop      = 1'b0;
        w_load_out = 1'b0;
        case (r_state)
            B_IDLE:  w_pop      = i_job_valid;
            B_SCALE: w_load_out = w_out_free;
            default: begin
                w_pop      = 1'b0;
                w_load_out = 1'b0;
            end
        endcase
    end

    assign o_job_pop  = w_pop;
    assign o_m_tvalid = r_out_valid;
    assign o_blurred  = r_out_data;
    assign o_last     = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_iss_q     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_iss_q <= (r_state == B_SUM);
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd      <= r_mem[w_rd_addr];
        r_edge_q  <= w_beyond;
        r_outer_q <= w_outer;

        if (w_pop) begin
            r_ptr    <= i_job_ptr;
            r_edge   <= i_job_edge;
            r_p      <= i_job.pos;
            r_eor    <= i_job.eor;
            r_centre <= i_job.emit_centre;
            r_d      <= i_job.emit_centre ? w_r + 1'b1 : w_flush_d_job;
        end

        if (r_state == B_START) begin
            r_k      <= KW'(w_k_lo);
            r_k_last <= KW'(w_k_hi);
            r_first  <= 1'b1;
        end else if (r_state == B_SUM) begin
            r_k     <= r_k + KW'(1);
            r_first <= 1'b0;
        end

        if (r_state == B_START) begin
            r_acc <= '0;
        end else if (r_iss_q) begin
            r_acc <= r_acc + w_term;
        end

        if (r_state == B_MUL) begin
            r_prod <= PW'(r_acc) * PW'($signed({1'b0, i_cfg.norm_recip}));
        end

        if (w_load_out) begin
            r_out_data <= w_blur;
            r_out_last <= !r_centre && (r_d == '0);
            // Advance to the next window centre of this job
            if (r_centre) begin
                r_centre <= 1'b0;
                r_d      <= w_flush_d_reg;
            end else begin
                r_d <= r_d - 1'b1;
            end
        end
    end

    a_mul_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_MUL) |-> ($past(r_state) == B_DRAIN))
        else $error("multiply entered without the accumulator drained");

    a_acc_from_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_iss_q |-> ($past(r_state) == B_SUM))
        else $error("accumulate without a tap issued");

    a_tap_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_SUM) |-> (r_k <= r_k_last))
        else $error("tap index ran past the window");

endmodule

`default_nettype wire
